>>> design/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants of the text/semigraphics pixel generator:
// item codes, register indexes, palette entries and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tsg_pkg;

  // item codes carried on mode_i
  localparam logic [1:0] MODE_VIDEO_WR = 2'd0;
  localparam logic [1:0] MODE_GLYPH_WR = 2'd1;
  localparam logic [1:0] MODE_RENDER   = 2'd2;

  // configuration register indexes
  localparam logic CFG_GRAPHICS_MODE  = 1'b0;
  localparam logic CFG_ALT_COLORS     = 1'b1;

  // glyph store geometry: 64 glyphs of 8 rows
  localparam int unsigned GLYPH_BYTES = 512;
  localparam int unsigned GLYPH_AW    = 9;

  // cell geometry in text mode
  localparam int unsigned CELL_ROWS   = 12;
  localparam logic [3:0]  GLYPH_TOP   = 4'd2;
  localparam logic [3:0]  SEMI_SPLIT  = 4'd6;

  // reciprocal of the cell height: y / 12 == (y * 171) >> 11 for 8-bit y
  localparam logic [7:0]  DIV12_MUL   = 8'd171;
  localparam int unsigned DIV12_SHIFT = 11;

  // palette entries
  localparam logic [3:0] COLOR_GFX_FG     = 4'd0;
  localparam logic [3:0] COLOR_GFX_ALT_FG = 4'd4;
  localparam logic [3:0] COLOR_BG         = 4'd8;
  localparam logic [3:0] COLOR_TEXT_FG    = 4'd0;
  localparam logic [3:0] COLOR_TEXT_BG    = 4'd9;
  localparam logic [3:0] COLOR_ALT_BG     = 4'd10;
  localparam logic [3:0] COLOR_ALT_FG     = 4'd11;

  // render sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VIDEO,
    ST_GLYPH
  } state_e;

endpackage

`default_nettype wire

>>> design/text_semigraphics_pixel_generator.sv
// ----------------------------------------------------------------------------
// text_semigraphics_pixel_generator
// Video memory and glyph store with a render path that turns one pixel
// position into a palette index, in bitmap or text/semigraphics mode.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start_i high and busy_o low.
//   mode_i selects a video memory write, a glyph store write or a render.
//   Writes land in the memory on the accept edge, give no result and keep
//   busy_o low, so a write can be taken every cycle while no render is running.
//   A render raises busy_o through ST_VIDEO and ST_GLYPH: the video byte is
//   read on the accept edge, the glyph row as ST_VIDEO ends. The color is
//   registered as ST_GLYPH ends and is on color_index_o with valid_o high
//   for one cycle; busy_o is low again in that cycle, so a new render can
//   be taken in it. The steps follow the two dependent synchronous reads.
//   Results cannot be held off: each beat is on the ports for one cycle only.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect on
//   the next edge; the user makes them while the block is idle, unchecked by it.
//   Reset clears the config registers, sequencer and valid_o; memory contents
//   are not cleared or guarded: the user reads them only after writing them.
// ----------------------------------------------------------------------------
`default_nettype none

module text_semigraphics_pixel_generator #(
  parameter int unsigned VIDEO_BYTES = 3072,
  parameter int unsigned SCREEN_ROWS = 192
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic       cfg_data_i,
  // command channel
  input  wire logic       start_i,
  output      logic       busy_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0] data_i,
  input  wire logic [7:0] pixel_x_i,
  input  wire logic [7:0] pixel_y_i,
  // result channel
  output      logic       valid_o,
  output      logic [3:0] color_index_o
);

  localparam int unsigned VideoAw = $clog2(VIDEO_BYTES);

  // configuration registers
  logic gfx_q, alt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfx_q <= 1'b0;
      alt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsg_pkg::CFG_GRAPHICS_MODE: gfx_q <= cfg_data_i;
        tsg_pkg::CFG_ALT_COLORS:    alt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state and result registers
  tsg_pkg::state_e state_q, state_d;
  logic            valid_q, valid_d;
  logic [3:0]      color_q, color_d;

  logic accept;
  assign busy_o = (state_q != tsg_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;

  // address decode of the command beat
  logic [15:0] row_prod;
  logic [4:0]  cell_row;
  logic [7:0]  cell_base;
  logic [3:0]  cy;
  logic [11:0] vaddr;
  logic        vaddr_ok;
  logic        row_ok;
  logic        video_we, glyph_we, video_re;

  always_comb begin
    row_prod  = 16'(pixel_y_i) * 16'(tsg_pkg::DIV12_MUL);
    cell_row  = row_prod[tsg_pkg::DIV12_SHIFT +: 5];
    cell_base = {cell_row, 3'b000} + {1'b0, cell_row, 2'b00};
    cy        = 4'(pixel_y_i - cell_base);
    if (gfx_q) begin
      vaddr = {pixel_y_i, pixel_x_i[7:4]};
    end else begin
      vaddr = {2'b00, cell_row, pixel_x_i[7:3]};
    end
    vaddr_ok = ({1'b0, vaddr} < 13'(VIDEO_BYTES));
    row_ok   = ({1'b0, pixel_y_i} < 9'(SCREEN_ROWS));
    video_we = accept && (mode_i == tsg_pkg::MODE_VIDEO_WR)
               && ({1'b0, address_i} < 13'(VIDEO_BYTES));
    glyph_we = accept && (mode_i == tsg_pkg::MODE_GLYPH_WR)
               && ({1'b0, address_i} < 13'(tsg_pkg::GLYPH_BYTES));
    video_re = accept && (mode_i == tsg_pkg::MODE_RENDER) && vaddr_ok;
  end

  // video memory
  logic [7:0] video_mem [VIDEO_BYTES];
  logic [7:0] video_rd_q;

  always_ff @(posedge clk_i) begin
    if (video_we) begin
      video_mem[address_i[VideoAw-1:0]] <= data_i;
    end
    if (video_re) begin
      video_rd_q <= video_mem[vaddr[VideoAw-1:0]];
    end
  end

  // render context carried past the video read
  logic [3:0] x_q;
  logic [3:0] cy_q;
  logic       row_ok_q;
  logic       vaddr_ok_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q        <= pixel_x_i[3:0];
      cy_q       <= cy;
      row_ok_q   <= row_ok;
      vaddr_ok_q <= vaddr_ok;
    end
  end

  // glyph row lookup from the video byte
  logic [7:0]                   vbyte;
  logic                         glyph_rows;
  logic [3:0]                   glyph_line;
  logic [tsg_pkg::GLYPH_AW-1:0] gaddr;
  logic                         glyph_re;

  always_comb begin
    vbyte      = vaddr_ok_q ? video_rd_q : 8'h00;
    glyph_rows = cy_q inside {[4'd2:4'd9]};
    glyph_line = cy_q - tsg_pkg::GLYPH_TOP;
    gaddr      = {vbyte[5:0], glyph_line[2:0]};
    glyph_re   = (state_q == tsg_pkg::ST_VIDEO) && glyph_rows;
  end

  // glyph store
  logic [7:0] glyph_mem [tsg_pkg::GLYPH_BYTES];
  logic [7:0] glyph_rd_q;

  always_ff @(posedge clk_i) begin
    if (glyph_we) begin
      glyph_mem[address_i[tsg_pkg::GLYPH_AW-1:0]] <= data_i;
    end
    if (glyph_re) begin
      glyph_rd_q <= glyph_mem[gaddr];
    end
  end

  // video byte and glyph window held for the color stage
  logic [7:0] v_q;
  logic       glyph_rows_q;

  always_ff @(posedge clk_i) begin
    if (state_q == tsg_pkg::ST_VIDEO) begin
      v_q          <= vbyte;
      glyph_rows_q <= glyph_rows;
    end
  end

  // pixel color from the held video byte and glyph row
  logic [3:0] pix_color;
  logic       gfx_bit, semi_bit, text_bit;
  logic [1:0] quad_sel;

  always_comb begin
    gfx_bit  = v_q[~x_q[3:1]];
    quad_sel = {~(cy_q >= tsg_pkg::SEMI_SPLIT), ~x_q[2]};
    semi_bit = v_q[quad_sel];
    text_bit = (glyph_rows_q && glyph_rd_q[x_q[2:0]]) ^ v_q[6];
    if (!row_ok_q) begin
      pix_color = tsg_pkg::COLOR_BG;
    end else if (gfx_q) begin
      if (gfx_bit) begin
        pix_color = alt_q ? tsg_pkg::COLOR_GFX_ALT_FG : tsg_pkg::COLOR_GFX_FG;
      end else begin
        pix_color = tsg_pkg::COLOR_BG;
      end
    end else if (v_q[7]) begin
      pix_color = semi_bit ? {1'b0, v_q[6:4]} : tsg_pkg::COLOR_BG;
    end else if (alt_q) begin
      pix_color = text_bit ? tsg_pkg::COLOR_ALT_FG : tsg_pkg::COLOR_ALT_BG;
    end else begin
      pix_color = text_bit ? tsg_pkg::COLOR_TEXT_FG : tsg_pkg::COLOR_TEXT_BG;
    end
  end

  // sequencer next state and result beat
  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    color_d = color_q;
    case (state_q)
      tsg_pkg::ST_IDLE: begin
        if (accept && (mode_i == tsg_pkg::MODE_RENDER)) begin
          state_d = tsg_pkg::ST_VIDEO;
        end
      end
      tsg_pkg::ST_VIDEO: begin
        state_d = tsg_pkg::ST_GLYPH;
      end
      tsg_pkg::ST_GLYPH: begin
        state_d = tsg_pkg::ST_IDLE;
        valid_d = 1'b1;
        color_d = pix_color;
      end
      default: begin
        state_d = tsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsg_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign valid_o       = valid_q;
  assign color_index_o = color_q;

endmodule

`default_nettype wire
